/* rtl/core/spool_pkg.sv */
// Shared types and constants for the slot pool.
`timescale 1ns / 1ps

package spool_pkg;

    localparam int FUNC_W = 2;
    localparam int SLOT_W = 8;
    localparam int SIZE_W = 9;
    localparam int COUNT_W = 9;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_WALK    = 2'd2;

    typedef struct packed {
        logic [SLOT_W-1:0]  granted_slot;
        logic               evicted;
        logic               list_end;
        logic               error;
        logic [COUNT_W-1:0] live_count;
    } result_t;

    typedef struct packed {
        logic rd_en;
        logic next_we;
        logic prev_we;
    } link_ctl_t;

endpackage

/* rtl/core/spool_ifs.sv */
// Handshake channel interfaces for the slot pool: requests, results and configuration.
`timescale 1ns / 1ps

interface spool_req_if;
    logic                         valid;
    logic                         ready;
    logic [spool_pkg::FUNC_W-1:0] func;
    logic [spool_pkg::SLOT_W-1:0] slot;
    logic                         from_head;

    modport source (output valid, func, slot, from_head, input ready);
    modport sink (input valid, func, slot, from_head, output ready);
endinterface

interface spool_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [spool_pkg::SLOT_W-1:0]  granted_slot;
    logic                          evicted;
    logic                          list_end;
    logic                          error;
    logic [spool_pkg::COUNT_W-1:0] live_count;

    modport source (output valid, granted_slot, evicted, list_end, error, live_count,
                    input ready);
    modport sink (input valid, granted_slot, evicted, list_end, error, live_count,
                  output ready);
endinterface

interface spool_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [spool_pkg::SIZE_W-1:0] pool_size;

    modport source (output valid, pool_size, input ready);
    modport sink (input valid, pool_size, output ready);
endinterface

/* rtl/core/spool_links.sv */
// Link memories: next link with busy flag, and previous link, one entry per slot.
`timescale 1ns / 1ps

module spool_links #(
    parameter int POOL_SLOTS = 256,
    localparam int SW = $clog2(POOL_SLOTS),
    localparam int LW = SW + 1
) (
    input  logic                 clk,
    input  spool_pkg::link_ctl_t ctl,
    input  logic [SW-1:0]        rd_addr,
    input  logic [SW-1:0]        next_wr_addr,
    input  logic [LW:0]          next_wr_data,
    input  logic [SW-1:0]        prev_wr_addr,
    input  logic [LW-1:0]        prev_wr_data,
    output logic [LW:0]          rd_next,
    output logic [LW-1:0]        rd_prev
);

    logic [LW:0]   next_mem [POOL_SLOTS];
    logic [LW-1:0] prev_mem [POOL_SLOTS];

    always_ff @(posedge clk)
    begin
        if (ctl.next_we)
        begin
            next_mem[next_wr_addr] <= next_wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_next <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.prev_we)
        begin
            prev_mem[prev_wr_addr] <= prev_wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_prev <= prev_mem[rd_addr];
        end
    end

endmodule

/* rtl/core/spool_ctrl.sv */
// Request sequencer: list pointers, read-modify-write of the link memories, result capture.
`timescale 1ns / 1ps

module spool_ctrl #(
    parameter int POOL_SLOTS = 256,
    localparam int SW = $clog2(POOL_SLOTS),
    localparam int LW = SW + 1,
    localparam int CW = SW + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    spool_cfg_if.sink            cfg,
    spool_req_if.sink            req,
    output spool_pkg::link_ctl_t mem_ctl,
    output logic [SW-1:0]        mem_rd_addr,
    output logic [SW-1:0]        mem_next_addr,
    output logic [LW:0]          mem_next_data,
    output logic [SW-1:0]        mem_prev_addr,
    output logic [LW-1:0]        mem_prev_data,
    input  logic [LW:0]          mem_rd_next,
    input  logic [LW-1:0]        mem_rd_prev,
    output logic                 res_valid,
    input  logic                 res_ready,
    output spool_pkg::result_t   res
);

    localparam int RST_POOL = (POOL_SLOTS < 256) ? POOL_SLOTS : 256;
    localparam logic [LW-1:0] NIL = {1'b1, SW'(0)};

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WR2  = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [CW-1:0]                pool_reg, pool_next;
    logic [CW-1:0]                fresh_reg, fresh_next;
    logic [LW-1:0]                free_head_reg, free_head_next;
    logic [LW-1:0]                head_reg, head_next;
    logic [LW-1:0]                tail_reg, tail_next;
    logic [CW-1:0]                total_reg, total_next;

    logic [spool_pkg::FUNC_W-1:0] func_reg, func_next;
    logic                         slot_ok_reg, slot_ok_next;
    logic                         from_head_reg, from_head_next;
    logic                         evict_reg, evict_next;
    logic                         fresh_hit_reg, fresh_hit_next;
    logic [SW-1:0]                addr_reg, addr_next;
    spool_pkg::result_t           res_reg, res_next;
    logic                         nb_we_reg, nb_we_next;
    logic [SW-1:0]                nb_addr_reg, nb_addr_next;
    logic [LW:0]                  nb_data_reg, nb_data_next;
    logic                         pb_we_reg, pb_we_next;
    logic [SW-1:0]                pb_addr_reg, pb_addr_next;
    logic [LW-1:0]                pb_data_reg, pb_data_next;

    logic                         accept;
    logic                         alloc_free;
    logic [SW-1:0]                rd_addr;
    logic [CW-1:0]                cfg_size;
    logic [LW-1:0]                s_link;
    logic [LW-1:0]                next_val;
    logic                         busy_val;
    logic [LW-1:0]                p_link;
    logic                         unl;
    logic [LW-1:0]                new_head;
    logic                         rel_ok;
    logic [LW-1:0]                found;
    logic                         a_next_we;
    logic [LW:0]                  a_next_data;
    logic                         a_prev_we;
    logic [SW-1:0]                a_prev_addr;
    logic [LW-1:0]                a_prev_data;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept = req.valid && req.ready;
    assign alloc_free = !free_head_reg[SW];

    always_comb
    begin
        if (req.func == spool_pkg::FUNC_ALLOC)
        begin
            rd_addr = alloc_free ? free_head_reg[SW-1:0] : tail_reg[SW-1:0];
        end
        else
        begin
            rd_addr = SW'(req.slot);
        end
    end

    always_comb
    begin
        if (cfg.pool_size == '0)
        begin
            cfg_size = CW'(1);
        end
        else if (int'(cfg.pool_size) > POOL_SLOTS)
        begin
            cfg_size = CW'(POOL_SLOTS);
        end
        else
        begin
            cfg_size = CW'(cfg.pool_size);
        end
    end

    // Slots below the fill count were never handed out, so their next link is
    // still the slot below and they are not busy; the memory output is not used for them.
    assign s_link = {1'b0, addr_reg};
    assign next_val = fresh_hit_reg ? ((addr_reg == '0) ? NIL : {1'b0, addr_reg - SW'(1)})
                                    : mem_rd_next[LW-1:0];
    assign busy_val = fresh_hit_reg ? 1'b0 : mem_rd_next[LW];
    assign p_link = mem_rd_prev;
    assign unl = !tail_reg[SW];
    assign new_head = (unl && p_link[SW]) ? NIL : head_reg;
    assign rel_ok = slot_ok_reg && busy_val;

    always_comb
    begin
        state_next = state_reg;
        pool_next = pool_reg;
        fresh_next = fresh_reg;
        free_head_next = free_head_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        total_next = total_reg;
        func_next = func_reg;
        slot_ok_next = slot_ok_reg;
        from_head_next = from_head_reg;
        evict_next = evict_reg;
        fresh_hit_next = fresh_hit_reg;
        addr_next = addr_reg;
        res_next = res_reg;
        nb_we_next = nb_we_reg;
        nb_addr_next = nb_addr_reg;
        nb_data_next = nb_data_reg;
        pb_we_next = pb_we_reg;
        pb_addr_next = pb_addr_reg;
        pb_data_next = pb_data_reg;
        a_next_we = 1'b0;
        a_next_data = {1'b1, head_reg};
        a_prev_we = 1'b0;
        a_prev_addr = addr_reg;
        a_prev_data = NIL;
        found = NIL;
        res_valid = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next = req.func;
                    slot_ok_next = int'(req.slot) < int'(pool_reg);
                    from_head_next = req.from_head;
                    evict_next = !alloc_free;
                    addr_next = rd_addr;
                    fresh_hit_next = {1'b0, rd_addr} < fresh_reg;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                nb_we_next = 1'b0;
                pb_we_next = 1'b0;
                res_next.granted_slot = '0;
                res_next.evicted = 1'b0;
                res_next.list_end = 1'b0;
                res_next.error = 1'b0;
                unique case (func_reg)
                    spool_pkg::FUNC_ALLOC:
                    begin
                        a_next_we = 1'b1;
                        a_prev_we = 1'b1;
                        a_prev_addr = addr_reg;
                        a_prev_data = NIL;
                        head_next = s_link;
                        res_next.granted_slot = spool_pkg::SLOT_W'(addr_reg);
                        if (!evict_reg)
                        begin
                            free_head_next = next_val;
                            if (fresh_hit_reg)
                            begin
                                fresh_next = {1'b0, addr_reg};
                            end
                            a_next_data = {1'b1, head_reg};
                            pb_we_next = !head_reg[SW];
                            pb_addr_next = head_reg[SW-1:0];
                            pb_data_next = s_link;
                            if (head_reg[SW])
                            begin
                                tail_next = s_link;
                            end
                            total_next = total_reg + CW'(1);
                        end
                        else
                        begin
                            // The oldest slot leaves the tail and comes back as the head.
                            a_next_data = {1'b1, new_head};
                            nb_we_next = unl && !p_link[SW];
                            nb_addr_next = p_link[SW-1:0];
                            nb_data_next = {1'b1, NIL};
                            pb_we_next = !new_head[SW];
                            pb_addr_next = new_head[SW-1:0];
                            pb_data_next = s_link;
                            if (new_head[SW])
                            begin
                                tail_next = s_link;
                            end
                            else
                            begin
                                tail_next = p_link;
                            end
                            if (!unl)
                            begin
                                total_next = total_reg + CW'(1);
                            end
                            res_next.evicted = 1'b1;
                        end
                    end
                    spool_pkg::FUNC_RELEASE:
                    begin
                        if (rel_ok)
                        begin
                            a_next_we = 1'b1;
                            a_next_data = {1'b0, free_head_reg};
                            a_prev_we = !next_val[SW];
                            a_prev_addr = next_val[SW-1:0];
                            a_prev_data = p_link;
                            nb_we_next = !p_link[SW];
                            nb_addr_next = p_link[SW-1:0];
                            nb_data_next = {1'b1, next_val};
                            if (p_link[SW])
                            begin
                                head_next = next_val;
                            end
                            if (next_val[SW])
                            begin
                                tail_next = p_link;
                            end
                            free_head_next = s_link;
                            total_next = total_reg - CW'(1);
                        end
                        else
                        begin
                            res_next.error = 1'b1;
                        end
                    end
                    spool_pkg::FUNC_WALK:
                    begin
                        if (from_head_reg)
                        begin
                            found = head_reg;
                        end
                        else if (rel_ok)
                        begin
                            found = next_val;
                        end
                        else
                        begin
                            res_next.error = 1'b1;
                        end
                        res_next.list_end = found[SW];
                        if (!found[SW])
                        begin
                            res_next.granted_slot = spool_pkg::SLOT_W'(found[SW-1:0]);
                        end
                    end
                    default:
                    begin
                        res_next.error = 1'b1;
                    end
                endcase
                res_next.live_count = spool_pkg::COUNT_W'(total_next);
                state_next = S_WR2;
            end
            S_WR2:
            begin
                res_valid = 1'b1;
                state_next = res_ready ? S_IDLE : S_HOLD;
            end
            S_HOLD:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase

        if (cfg.valid)
        begin
            pool_next = cfg_size;
            fresh_next = cfg_size;
            free_head_next = LW'(cfg_size - CW'(1));
            head_next = NIL;
            tail_next = NIL;
            total_next = '0;
        end
    end

    // Entry writes of the first step go out in S_EXEC, the deferred ones in S_WR2.
    always_comb
    begin
        mem_ctl.rd_en = accept;
        mem_rd_addr = rd_addr;
        if (state_reg == S_EXEC)
        begin
            mem_ctl.next_we = a_next_we;
            mem_ctl.prev_we = a_prev_we;
            mem_next_addr = addr_reg;
            mem_next_data = a_next_data;
            mem_prev_addr = a_prev_addr;
            mem_prev_data = a_prev_data;
        end
        else
        begin
            mem_ctl.next_we = (state_reg == S_WR2) && nb_we_reg;
            mem_ctl.prev_we = (state_reg == S_WR2) && pb_we_reg;
            mem_next_addr = nb_addr_reg;
            mem_next_data = nb_data_reg;
            mem_prev_addr = pb_addr_reg;
            mem_prev_data = pb_data_reg;
        end
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pool_reg <= CW'(RST_POOL);
            fresh_reg <= CW'(RST_POOL);
            free_head_reg <= LW'(RST_POOL - 1);
            head_reg <= NIL;
            tail_reg <= NIL;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pool_reg <= pool_next;
            fresh_reg <= fresh_next;
            free_head_reg <= free_head_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        slot_ok_reg <= slot_ok_next;
        from_head_reg <= from_head_next;
        evict_reg <= evict_next;
        fresh_hit_reg <= fresh_hit_next;
        addr_reg <= addr_next;
        res_reg <= res_next;
        nb_we_reg <= nb_we_next;
        nb_addr_reg <= nb_addr_next;
        nb_data_reg <= nb_data_next;
        pb_we_reg <= pb_we_next;
        pb_addr_reg <= pb_addr_next;
        pb_data_reg <= pb_data_next;
    end

endmodule

/* rtl/core/slot_pool_with_oldest_eviction.sv */
// Top level of the slot pool: sequencer, link memories and output register.
`timescale 1ns / 1ps

// Slot pool with oldest-first eviction.
// req carries one item per request: func selects allocate, release or walk, slot
// names the slot to release or to step from, and from_head starts a walk at the
// newest active slot. rsp returns one item per request with the granted or found
// slot, the eviction, end-of-list and error flags, and the live slot count.
// cfg writes pool_size; each write frees every slot. Write it only while idle.
// An item reaches the output register from S_WR2 or S_HOLD: the link memories
// are read at the accepting edge, S_EXEC writes the first entries and S_WR2 the
// deferred ones, since a request changes up to two entries of each memory. The
// sequencer returns to idle for the next request once the output register takes
// the result, and takes no new request before the last one is through.
// After reset, pool_size is the smaller of POOL_SLOTS and 256, with all slots
// free. There is no clearing pass: a fill count marks slots never handed out.
// When the receiver stalls, one result waits in the output register and one more
// inside the sequencer; further requests are then held off until rsp drains.

module slot_pool_with_oldest_eviction #(
    parameter int POOL_SLOTS = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    spool_cfg_if.sink  cfg,
    spool_req_if.sink  req,
    spool_rsp_if.source rsp
);

    localparam int SW = $clog2(POOL_SLOTS);
    localparam int LW = SW + 1;

    spool_pkg::link_ctl_t mem_ctl;
    logic [SW-1:0]        mem_rd_addr;
    logic [SW-1:0]        mem_next_addr;
    logic [LW:0]          mem_next_data;
    logic [SW-1:0]        mem_prev_addr;
    logic [LW-1:0]        mem_prev_data;
    logic [LW:0]          mem_rd_next;
    logic [LW-1:0]        mem_rd_prev;
    logic                 res_valid;
    logic                 res_ready;
    spool_pkg::result_t   res;

    logic                 out_valid_reg, out_valid_next;
    spool_pkg::result_t   out_data_reg, out_data_next;

    spool_ctrl #(
        .POOL_SLOTS(POOL_SLOTS)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg),
        .req(req),
        .mem_ctl(mem_ctl),
        .mem_rd_addr(mem_rd_addr),
        .mem_next_addr(mem_next_addr),
        .mem_next_data(mem_next_data),
        .mem_prev_addr(mem_prev_addr),
        .mem_prev_data(mem_prev_data),
        .mem_rd_next(mem_rd_next),
        .mem_rd_prev(mem_rd_prev),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res)
    );

    spool_links #(
        .POOL_SLOTS(POOL_SLOTS)
    ) u_links (
        .clk(clk),
        .ctl(mem_ctl),
        .rd_addr(mem_rd_addr),
        .next_wr_addr(mem_next_addr),
        .next_wr_data(mem_next_data),
        .prev_wr_addr(mem_prev_addr),
        .prev_wr_data(mem_prev_data),
        .rd_next(mem_rd_next),
        .rd_prev(mem_rd_prev)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.granted_slot = out_data_reg.granted_slot;
    assign rsp.evicted = out_data_reg.evicted;
    assign rsp.list_end = out_data_reg.list_end;
    assign rsp.error = out_data_reg.error;
    assign rsp.live_count = out_data_reg.live_count;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready ##1 !req.ready)
        else $error("request accepted while the previous one is still in work");

    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("internal result changed while waiting for the output register");

    a_evict_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.evicted |-> !rsp.error && !rsp.list_end)
        else $error("evicting allocation reported an error or end of list");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.list_end |-> rsp.granted_slot == '0)
        else $error("end of list reported with a nonzero slot");
`endif

endmodule
